// File: rtl/lmt_pkg.sv
// Shared types and constants for the meteor trail frame engine.
package lmt_pkg;

  localparam int MAX_PIXELS_DEF = 64;

  localparam int CH_W  = 8;
  localparam int RGB_W = 3 * CH_W;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int POS_W = 8;

  localparam logic [CH_W-1:0] FADE_FLOOR = 8'd10;

  localparam logic [2:0] REG_COLOR  = 3'd0;
  localparam logic [2:0] REG_LENGTH = 3'd1;
  localparam logic [2:0] REG_FADE   = 3'd2;
  localparam logic [2:0] REG_DECAY  = 3'd3;
  localparam logic [2:0] REG_ACTIVE = 3'd4;

  typedef struct packed {
    logic fade_en;
    logic paint_en;
  } pix_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
    logic             last;
  } pix_item_t;

endpackage

// File: rtl/lmt_pix_calc.sv
// Per-pixel update: channel fade toward black, then meteor paint.
module lmt_pix_calc (
  input  logic [lmt_pkg::RGB_W-1:0] rgb_in,
  input  lmt_pkg::pix_ctl_t         ctl,
  input  logic [lmt_pkg::CH_W-1:0]  fade,
  input  logic [lmt_pkg::RGB_W-1:0] color,
  output logic [lmt_pkg::RGB_W-1:0] rgb_out
);
  import lmt_pkg::*;

  logic [RGB_W-1:0] faded;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [CH_W-1:0]   c;
    logic [2*CH_W-1:0] prod;
    assign c    = rgb_in[ch*CH_W +: CH_W];
    assign prod = (2*CH_W)'(c) * (2*CH_W)'(fade);
    // Dim channels snap straight to black.
    assign faded[ch*CH_W +: CH_W] = (c <= FADE_FLOOR) ? '0 : c - prod[2*CH_W-1:CH_W];
  end

  always_comb begin
    priority if (ctl.paint_en) begin
      rgb_out = color;
    end else if (ctl.fade_en) begin
      rgb_out = faded;
    end else begin
      rgb_out = rgb_in;
    end
  end

endmodule

// File: rtl/led_meteor_trail_frame_engine_top.sv
// Top level of the meteor trail frame engine: control, frame buffer and output queue.
//
// Each input item is one frame tick carrying a 64-bit fade mask. For that tick the
// block walks the strip once, pixel 0 first: it reads the stored color, fades it
// (masked pixels only, or all pixels when random decay is off), paints the meteor
// color on the pixels at and behind the meteor position, writes the color back and
// sends one result item per pixel, with out_last_pixel set on the final one.
// The position then advances and wraps to 0 once it passes twice the strip size.
//
// The frame buffer is a synchronous memory with one read port and one write port and
// a registered read. One pixel is read, updated and written back per cycle while the
// output queue has room; the first pixel of a frame is offered once it has passed the
// read register and the output queue. The next tick is taken as soon as the last
// pixel has been written back, even while results still wait in the two-entry
// output queue.
// When out_ready is low the queue fills and reads stop; nothing is lost.
// Reset restores the register defaults, sets the position to zero and clears the
// per-pixel valid bits, so the strip reads as black at once with no clearing pass.
// Configuration must be written through the APB port only while no frame is in flight; the block does not enforce it.
module led_meteor_trail_frame_engine_top #(
  parameter int MAX_PIXELS = lmt_pkg::MAX_PIXELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [63:0]               in_fade_mask,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [lmt_pkg::IDX_W-1:0] out_pixel_index,
  output logic [lmt_pkg::CH_W-1:0]  out_red,
  output logic [lmt_pkg::CH_W-1:0]  out_green,
  output logic [lmt_pkg::CH_W-1:0]  out_blue,
  output logic                      out_last_pixel,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lmt_pkg::*;

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  // Configuration registers.
  logic [RGB_W-1:0] color_r;
  logic [CNT_W-1:0] len_r;
  logic [CH_W-1:0]  fade_r;
  logic             decay_r;
  logic [CNT_W-1:0] active_r;

  // Frame control.
  logic             state_r, state_nxt;
  logic [63:0]      mask_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] strip_size;
  logic [POS_W-1:0] pos_inc;

  // Read stage.
  logic             rd_en;
  logic             rd_vld_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             rd_last_r;
  logic             rd_hit_r;
  logic [RGB_W-1:0] mem_q_r;

  // Frame buffer and its valid bits.
  logic [RGB_W-1:0]      mem [MAX_PIXELS];
  logic [MAX_PIXELS-1:0] pv_r;

  logic [RGB_W-1:0] old_rgb;
  logic [RGB_W-1:0] new_rgb;
  pix_ctl_t         ctl;

  // Output queue.
  pix_item_t  q_r [2];
  logic       q_wptr_r, q_rptr_r;
  logic [1:0] q_cnt_r;
  logic [1:0] q_occ;
  logic       push, pop;

  logic cfg_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r  <= 24'hFF_FFFF;
      len_r    <= 7'd12;
      fade_r   <= 8'd63;
      decay_r  <= 1'b1;
      active_r <= 7'd64;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_COLOR:  color_r  <= pwdata[RGB_W-1:0];
        REG_LENGTH: len_r    <= pwdata[CNT_W-1:0];
        REG_FADE:   fade_r   <= pwdata[CH_W-1:0];
        REG_DECAY:  decay_r  <= pwdata[0];
        REG_ACTIVE: active_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COLOR:  prdata = 32'(color_r);
      REG_LENGTH: prdata = 32'(len_r);
      REG_FADE:   prdata = 32'(fade_r);
      REG_DECAY:  prdata = 32'(decay_r);
      REG_ACTIVE: prdata = 32'(active_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- frame control ----------------
  // A strip size of zero counts as one pixel; sizes above the buffer are clipped.
  always_comb begin
    priority if (active_r == '0) begin
      strip_size = CNT_W'(1);
    end else if (active_r > CNT_W'(MAX_PIXELS)) begin
      strip_size = CNT_W'(MAX_PIXELS);
    end else begin
      strip_size = active_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Reads are issued only when the queue is sure to have room when the data lands.
  assign push  = rd_vld_r;
  assign pop   = out_valid && out_ready;
  assign q_occ = q_cnt_r - {1'b0, pop} + {1'b0, push};
  assign rd_en = (state_r == ST_RUN) && (cnt_r < count_r) && (q_occ < 2'd2);

  assign pos_inc = pos_r + POS_W'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (rd_en) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        // The frame ends once the last pixel is written back.
        if (push && rd_last_r) begin
          state_nxt = ST_IDLE;
          pos_nxt   = (pos_inc > {count_r, 1'b0}) ? '0 : pos_inc;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pos_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mask_r  <= in_fade_mask;
      count_r <= strip_size;
    end
    if (rd_en) begin
      rd_idx_r  <= cnt_r;
      rd_last_r <= (cnt_r + CNT_W'(1)) == count_r;
      rd_hit_r  <= pv_r[cnt_r[AW-1:0]];
    end
  end

  // ---------------- frame buffer ----------------
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[cnt_r[AW-1:0]];
    end
    if (push) begin
      mem[rd_idx_r[AW-1:0]] <= new_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (push) begin
      pv_r[rd_idx_r[AW-1:0]] <= 1'b1;
    end
  end

  // A pixel never written since reset is black.
  assign old_rgb = rd_hit_r ? mem_q_r : '0;

  assign ctl.fade_en  = !decay_r || mask_r[rd_idx_r[IDX_W-1:0]];
  assign ctl.paint_en = (POS_W'(rd_idx_r) <= pos_r) &&
                        ((pos_r - POS_W'(rd_idx_r)) < POS_W'(len_r));

  lmt_pix_calc u_calc (
    .rgb_in  (old_rgb),
    .ctl     (ctl),
    .fade    (fade_r),
    .color   (color_r),
    .rgb_out (new_rgb)
  );

  // ---------------- output queue ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wptr_r <= 1'b0;
      q_rptr_r <= 1'b0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        q_wptr_r <= !q_wptr_r;
      end
      if (pop) begin
        q_rptr_r <= !q_rptr_r;
      end
      q_cnt_r <= q_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[q_wptr_r] <= '{idx: rd_idx_r[IDX_W-1:0], rgb: new_rgb, last: rd_last_r};
    end
  end

  assign out_valid       = (q_cnt_r != '0);
  assign out_pixel_index = q_r[q_rptr_r].idx;
  assign out_red         = q_r[q_rptr_r].rgb[3*CH_W-1:2*CH_W];
  assign out_green       = q_r[q_rptr_r].rgb[2*CH_W-1:CH_W];
  assign out_blue        = q_r[q_rptr_r].rgb[CH_W-1:0];
  assign out_last_pixel  = q_r[q_rptr_r].last;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the meteor trail frame engine: frame ticks in, pixel items out.
`timescale 1ns / 100ps

module tb;

  import lmt_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The longest
  // quiet stretch in a correct run is the deliberate receiver hold-off below.
  localparam int QUIET_LIMIT = 2500;
  // Length of the deliberate receiver hold-off that fills the block and stalls its input.
  localparam int LONG_HOLD = 400;
  // Cycles granted after the last result so the final write-back can finish.
  localparam int SETTLE_CYCLES = 8;
  // Register indexes that decode to no register at all.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // One pixel item as the block should send it.
  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last;
  } pixel_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [63:0]       in_fade_mask = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_pixel_index;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic              out_last_pixel;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [4:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  led_meteor_trail_frame_engine_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_fade_mask    (in_fade_mask),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Stimulus and scoreboard storage.
  logic [63:0] mask_q[$];
  pixel_out_t  pixel_q[$];
  int          mismatch_count = 0;

  // Traffic shaping knobs, owned by the sequencing initial block.
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_requests   = 0;

  // The testbench's own copy of the configuration and of the strip state.
  logic [RGB_W-1:0] shadow_color;
  logic [CNT_W-1:0] shadow_length;
  logic [CH_W-1:0]  shadow_fade;
  logic             shadow_decay;
  logic [CNT_W-1:0] shadow_active;
  logic [RGB_W-1:0] strip_rgb[MAX_PIXELS_DEF];
  logic [POS_W-1:0] head_pos;

  initial begin
    forever #6 clk = ~clk;
  end

  // The number of pixels on the strip: zero counts as one, anything past the
  // buffer size counts as the buffer size.
  function automatic int strip_len();
    if (shadow_active < 1) return 1;
    if (shadow_active > MAX_PIXELS_DEF) return MAX_PIXELS_DEF;
    return shadow_active;
  endfunction

  // A dim channel drops straight to black; a brighter one loses fade/256 of itself.
  function automatic logic [CH_W-1:0] faded_channel(input logic [CH_W-1:0] c);
    logic [2*CH_W-1:0] prod;
    if (c <= FADE_FLOOR) return '0;
    prod = c * shadow_fade;
    return c - prod[2*CH_W-1:CH_W];
  endfunction

  function automatic logic [RGB_W-1:0] faded_rgb(input logic [RGB_W-1:0] rgb);
    return {faded_channel(rgb[23:16]), faded_channel(rgb[15:8]), faded_channel(rgb[7:0])};
  endfunction

  // Advances the strip by one frame tick and queues the pixels it must send.
  task automatic render_frame(input logic [63:0] mask);
    int         n;
    int         p;
    pixel_out_t px;
    n = strip_len();
    for (int i = 0; i < n; i++) begin
      if (!shadow_decay || mask[i]) strip_rgb[i] = faded_rgb(strip_rgb[i]);
    end
    // The head sits at the position and the tail runs toward pixel 0; pixels
    // past the end of the strip are not touched.
    for (int k = 0; k < shadow_length; k++) begin
      if (k <= head_pos) begin
        p = head_pos - k;
        if (p < n) strip_rgb[p] = shadow_color;
      end
    end
    for (int i = 0; i < n; i++) begin
      px.idx   = i[IDX_W-1:0];
      px.red   = strip_rgb[i][23:16];
      px.green = strip_rgb[i][15:8];
      px.blue  = strip_rgb[i][7:0];
      px.last  = (i == n - 1);
      pixel_q.push_back(px);
    end
    head_pos = head_pos + 1'b1;
    if (head_pos > 2 * n) head_pos = '0;
  endtask

  // Driver: offers queued frame ticks, holding each one until it is taken. The
  // shadow strip is advanced at the edge on which the tick is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) render_frame(in_fade_mask);
      if (!in_valid || in_ready) begin
        if (mask_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid     <= 1'b1;
          in_fade_mask <= mask_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted pixel against the oldest expectation and
  // drives out_ready, including the long hold-off that it counts itself.
  int hold_served = 0;
  int hold_left   = 0;

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel item idx=%0d rgb=%02h%02h%02h last=%0b", $time,
                   out_pixel_index, out_red, out_green, out_blue, out_last_pixel);
        end else begin
          want = pixel_q.pop_front();
          if (out_pixel_index !== want.idx || out_red !== want.red ||
              out_green !== want.green || out_blue !== want.blue ||
              out_last_pixel !== want.last) begin
            mismatch_count++;
            $display("%0t: pixel mismatch expected idx=%0d rgb=%02h%02h%02h last=%0b",
                     $time, want.idx, want.red, want.green, want.blue, want.last);
            $display("%0t:                  actual idx=%0d rgb=%02h%02h%02h last=%0b",
                     $time, out_pixel_index, out_red, out_green, out_blue, out_last_pixel);
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // APB write: a setup cycle, then an access cycle that completes when pready
  // is seen high. The shadow copy is updated once the write has landed.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COLOR:  shadow_color  = value[RGB_W-1:0];
      REG_LENGTH: shadow_length = value[CNT_W-1:0];
      REG_FADE:   shadow_fade   = value[CH_W-1:0];
      REG_DECAY:  shadow_decay  = value[0];
      REG_ACTIVE: shadow_active = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] color, input logic [31:0] length,
                         input logic [31:0] fade, input logic [31:0] decay,
                         input logic [31:0] active);
    write_reg(REG_COLOR, color);
    write_reg(REG_LENGTH, length);
    write_reg(REG_FADE, fade);
    write_reg(REG_DECAY, decay);
    write_reg(REG_ACTIVE, active);
  endtask

  // Blocks until every queued tick has been taken and every pixel has come out,
  // then lets the block finish its last write-back. The check runs on the falling
  // edge so that the driver's updates from the rising edge are already visible.
  task automatic wait_drained();
    while (mask_q.size() != 0 || in_valid || pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly dense random masks, with the all-clear and all-set cases mixed in.
  function automatic logic [63:0] rand_mask();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // A random setting, with the strip size sometimes zero or past the buffer so
  // that clamping stays exercised.
  task automatic random_setting();
    set_all($urandom(), $urandom_range(0, 127), $urandom(), $urandom_range(0, 1),
            $urandom_range(0, 72));
  endtask

  initial begin
    // Shadow state matches what reset leaves in the block.
    shadow_color  = 24'hFFFFFF;
    shadow_length = 7'd12;
    shadow_fade   = 8'd63;
    shadow_decay  = 1'b1;
    shadow_active = 7'd64;
    head_pos      = '0;
    for (int i = 0; i < MAX_PIXELS_DEF; i++) strip_rgb[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part. The reset defaults first, with the mask extremes and
    // alternating patterns.
    mask_q.push_back(64'h0);
    mask_q.push_back('1);
    mask_q.push_back(64'h5555_5555_5555_5555);
    mask_q.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    mask_q.push_back(64'h8000_0000_0000_0001);
    wait_drained();

    // Strip size of zero acts as a single pixel; no meteor is drawn, no fade is
    // applied beyond the dim-to-black rule, and every pixel fades.
    set_all(32'h000B0A, 0, 0, 0, 0);
    mask_q.push_back(64'h0);
    mask_q.push_back('1);
    wait_drained();

    // Strip size above the buffer clamps to the full strip, and a meteor longer
    // than the strip paints only what lies on it. Full fade with channels right
    // at the black threshold.
    set_all(32'hFF0B0A0C, 127, 255, 1, 127);
    mask_q.push_back('1);
    mask_q.push_back(64'h0);
    mask_q.push_back(64'hF0F0_0F0F_3C3C_C3C3);
    wait_drained();

    // A short strip ignores mask bits beyond its end and leaves the pixels past
    // it untouched.
    set_all($urandom(), 64, 128, 1, 10);
    mask_q.push_back(64'hFFFF_FFFF_FFFF_FC00);
    mask_q.push_back(64'h0000_0000_0000_03FF);
    wait_drained();
    write_reg(REG_DECAY, 0);
    mask_q.push_back(64'h0);
    wait_drained();

    // Writes to addresses with no register behind them must change nothing.
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, $urandom());
    mask_q.push_back({$urandom(), $urandom()});
    mask_q.push_back('1);
    wait_drained();

    // A one-pixel strip wraps the position after two, so a few ticks walk the
    // head off the strip and back.
    set_all(32'h00FF00, 1, 200, 1, 1);
    for (int i = 0; i < 5; i++) mask_q.push_back(rand_mask());
    wait_drained();

    // Random part. Phase 0: no idling on either side.
    random_setting();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    for (int i = 0; i < 50; i++) mask_q.push_back(rand_mask());
    wait_drained();

    // Phase 1: the sender is idle most of the time.
    random_setting();
    sender_idle_pct = 74;
    recv_stall_pct  = 0;
    for (int i = 0; i < 50; i++) mask_q.push_back(rand_mask());
    wait_drained();

    // Phase 2: the receiver stalls most of the time.
    random_setting();
    sender_idle_pct = 0;
    recv_stall_pct  = 74;
    for (int i = 0; i < 50; i++) mask_q.push_back(rand_mask());
    wait_drained();

    // Phase 3: both sides idle now and then. The sender also pauses after each
    // batch until every pixel of the batch has come out.
    random_setting();
    sender_idle_pct = 23;
    recv_stall_pct  = 23;
    for (int b = 0; b < 5; b++) begin
      for (int i = 0; i < 10; i++) mask_q.push_back(rand_mask());
      wait_drained();
    end

    // Phase 4: the receiver holds off for a long stretch while the sender keeps
    // offering ticks, so the output queue fills and the input stalls. Back to
    // the reset-like full strip so the position has room to run up to its wrap.
    set_all($urandom(), 12, 63, 1, 64);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    for (int i = 0; i < 50; i++) mask_q.push_back(rand_mask());
    hold_requests++;
    wait_drained();

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
